// ===== hdl/q_routing_gate_select_assert.svh =====
// Assertion macros used by the checker file.
`ifndef Q_ROUTING_GATE_SELECT_ASSERT_SVH
`define Q_ROUTING_GATE_SELECT_ASSERT_SVH
`define QRG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define QRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/qrg_pkg.sv =====
// Package with shared types and codes of the gate selector.
`default_nettype none
package qrg_pkg;
  localparam int DEST_COUNT = 16;
  localparam int MAX_GATES = 8;

  localparam logic [1:0] ActData = 2'd0;
  localparam logic [1:0] ActResp = 2'd1;
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindExplore = 2'd1;
  localparam logic [1:0] KindRandom = 2'd2;
  localparam logic [1:0] KindGreedy = 2'd3;
  localparam logic [1:0] RegRate = 2'd0;
  localparam logic [1:0] RegEps = 2'd1;
  localparam logic [1:0] RegInitQ = 2'd2;
  localparam logic [1:0] RegGates = 2'd3;

  typedef enum logic [3:0] {
    StIdle, StSearch, StQRead, StMul, StLearn, StShift, StGateScan, StFinish, StOut
  } state_e;

  typedef struct packed {
    logic start;
    logic search;
    logic q_read;
    logic mul;
    logic learn;
    logic shift;
    logic scan;
    logic finish;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic search_done;
    logic found;
    logic shift_done;
    logic scan_done;
    logic is_resp;
  } stat_t;
endpackage
`default_nettype wire

// ===== hdl/qrg_ctrl.sv =====
// Controller state machine of the gate selector.
`default_nettype none
module qrg_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_fire_i,
  input  wire logic           out_free_i,
  input  wire qrg_pkg::stat_t stat_i,
  output qrg_pkg::ctrl_t      ctrl_o,
  output logic                busy_o
);
  import qrg_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_fire_i) state_d = stat_i.is_resp ? StSearch : StGateScan;
      StSearch: begin
        if (stat_i.found) state_d = StQRead;
        else if (stat_i.search_done) state_d = StGateScan;
      end
      StQRead: state_d = StMul;
      StMul: state_d = StLearn;
      StLearn: state_d = StShift;
      StShift: if (stat_i.shift_done) state_d = StGateScan;
      StGateScan: if (stat_i.scan_done) state_d = StFinish;
      StFinish: state_d = StOut;
      StOut: if (out_free_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.start = (state_q == StIdle) && in_fire_i;
    case (state_q)
      StSearch: ctrl_o.search = 1'b1;
      StQRead: ctrl_o.q_read = 1'b1;
      StMul: ctrl_o.mul = 1'b1;
      StLearn: ctrl_o.learn = 1'b1;
      StShift: ctrl_o.shift = 1'b1;
      StGateScan: ctrl_o.scan = 1'b1;
      StFinish: ctrl_o.finish = 1'b1;
      StOut: ctrl_o.out_load = out_free_i;
      default: ;
    endcase
    busy_o = (state_q != StIdle);
  end
endmodule
`default_nettype wire

// ===== hdl/qrg_datapath.sv =====
// Datapath of the gate selector: tables, pending list, learning and choice.
`default_nettype none
module qrg_datapath #(
  parameter int PENDING_DEPTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire qrg_pkg::ctrl_t ctrl_i,
  output qrg_pkg::stat_t      stat_o,
  input  wire logic [1:0]     action_i,
  input  wire logic [3:0]     dest_i,
  input  wire logic [3:0]     src_i,
  input  wire logic [2:0]     in_gate_i,
  input  wire logic           has_in_gate_i,
  input  wire logic [31:0]    now_i,
  input  wire logic [15:0]    rand_threshold_i,
  input  wire logic [15:0]    rand_pick_i,
  input  wire logic [15:0]    learning_rate_i,
  input  wire logic [15:0]    epsilon_i,
  input  wire logic [39:0]    initial_q_i,
  input  wire logic [3:0]     num_gates_i,
  output logic                forwarded_o,
  output logic [2:0]          out_gate_o,
  output logic [1:0]          choice_kind_o,
  output logic                learned_o,
  output logic [39:0]         new_q_o,
  output logic                pending_full_o
);
  import qrg_pkg::*;
  localparam int DW = (DEST_COUNT > 1) ? $clog2(DEST_COUNT) : 1;
  localparam int GW = $clog2(MAX_GATES);
  localparam int GCW = $clog2(MAX_GATES + 1);
  localparam int PW = $clog2(PENDING_DEPTH);
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int QAW = DW + GW;

  logic [39:0] q_mem [DEST_COUNT * MAX_GATES];
  logic [MAX_GATES-1:0] q_valid_q [DEST_COUNT];
  logic [MAX_GATES-1:0] explored_q [DEST_COUNT];
  logic [DW-1:0] pend_dest_q [PENDING_DEPTH];
  logic [GW-1:0] pend_gate_q [PENDING_DEPTH];
  logic [31:0] pend_time_q [PENDING_DEPTH];
  logic [PCW-1:0] pend_count_q;

  logic [1:0] act_q;
  logic [DW-1:0] dest_q, src_q;
  logic [GW-1:0] in_gate_q;
  logic has_in_q;
  logic [31:0] now_q;
  logic [15:0] rthr_q, rpick_q;

  logic [PW-1:0] idx_q;
  logic [GCW-1:0] g_q;
  logic [39:0] old_q, rtt_q, diff_q, bq_q, qrd_q;
  logic ge_q;
  logic [55:0] prod_w;
  logic [GCW-1:0] n_w;
  logic [MAX_GATES-1:0] avail_w, unexp_w;
  logic [GCW-1:0] count_w;
  logic [GW-1:0] best_q, first_w, rand_g_w;
  logic best_set_q;
  logic found_w;
  logic [31:0] rtt_w;
  logic [39:0] nq_w;
  logic [GCW+15:0] pick_w;
  logic [GCW-1:0] pidx_w;
  logic [GCW-1:0] k_w;
  logic first_found_w, rand_found_w;
  logic learned_q;
  logic [39:0] nq_q;
  logic [1:0] kind_q;
  logic [GW-1:0] gate_q;
  logic full_q;
  logic [GW-1:0] g_idx_w;

  assign n_w = (num_gates_i > 4'(MAX_GATES)) ? GCW'(MAX_GATES) : GCW'(num_gates_i);
  always_comb begin
    avail_w = '0;
    count_w = '0;
    for (int g = 0; g < MAX_GATES; g++) begin
      if ((GCW'(g) < n_w) && !(has_in_q && in_gate_q == GW'(g))) begin
        avail_w[g] = 1'b1;
        count_w = count_w + 1'b1;
      end
    end
    unexp_w = avail_w & ~explored_q[dest_q];
    first_w = '0;
    first_found_w = 1'b0;
    for (int g = 0; g < MAX_GATES; g++) begin
      if (unexp_w[g] && !first_found_w) begin
        first_w = GW'(g);
        first_found_w = 1'b1;
      end
    end
    pick_w = GCW'(count_w) * rpick_q;
    pidx_w = pick_w[GCW+15:16];
    rand_g_w = '0;
    rand_found_w = 1'b0;
    k_w = '0;
    for (int g = 0; g < MAX_GATES; g++) begin
      if (avail_w[g] && !rand_found_w) begin
        if (k_w == pidx_w) begin
          rand_g_w = GW'(g);
          rand_found_w = 1'b1;
        end
        k_w = k_w + 1'b1;
      end
    end
  end

  assign g_idx_w = g_q[GW-1:0];
  assign found_w = ctrl_i.search && (PCW'(idx_q) < pend_count_q)
                   && pend_dest_q[idx_q] == src_q && pend_gate_q[idx_q] == in_gate_q;
  assign rtt_w = now_q - pend_time_q[idx_q];
  assign prod_w = 56'(diff_q) * 56'(learning_rate_i);
  assign nq_w = ge_q ? (old_q + 40'(prod_w[55:16])) : (old_q - 40'(prod_w[55:16]));

  assign stat_o.found = found_w;
  assign stat_o.search_done = (PCW'(idx_q) + 1'b1 >= pend_count_q) || (idx_q == PW'(PENDING_DEPTH - 1));
  assign stat_o.shift_done = (PCW'(idx_q) + 1'b1 >= pend_count_q) || (idx_q == PW'(PENDING_DEPTH - 1));
  assign stat_o.scan_done = (g_q + 1'b1 >= GCW'(MAX_GATES));
  assign stat_o.is_resp = (action_i == ActResp) && has_in_gate_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.q_read) qrd_q <= q_mem[{src_q, in_gate_q[GW-1:0]}];
    if (ctrl_i.learn) q_mem[{src_q, in_gate_q[GW-1:0]}] <= nq_w;
    if (ctrl_i.scan && avail_w[g_idx_w]) qrd_q <= q_mem[QAW'({dest_q, g_idx_w})];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_count_q <= '0;
      for (int i = 0; i < DEST_COUNT; i++) begin
        q_valid_q[i] <= '0;
        explored_q[i] <= '0;
      end
      act_q <= '0;
    end else begin
      if (ctrl_i.start) begin
        act_q <= action_i;
        dest_q <= DW'(dest_i);
        src_q <= DW'(src_i);
        in_gate_q <= in_gate_i;
        has_in_q <= has_in_gate_i;
        now_q <= now_i;
        rthr_q <= rand_threshold_i;
        rpick_q <= rand_pick_i;
        idx_q <= '0;
        g_q <= '0;
        learned_q <= 1'b0;
        nq_q <= '0;
        best_set_q <= 1'b0;
        bq_q <= '0;
        best_q <= '0;
      end
      if (ctrl_i.search) begin
        if (found_w) rtt_q <= {rtt_w, 8'h00};
        else idx_q <= idx_q + 1'b1;
      end
      if (ctrl_i.mul) begin
        old_q <= q_valid_q[src_q][in_gate_q[GW-1:0]] ? qrd_q : initial_q_i;
      end
      if (ctrl_i.q_read) begin
      end
      if (ctrl_i.learn) begin
        q_valid_q[src_q][in_gate_q[GW-1:0]] <= 1'b1;
        learned_q <= 1'b1;
        nq_q <= nq_w;
        pend_count_q <= pend_count_q - 1'b1;
      end
      if (ctrl_i.shift) begin
        if (PCW'(idx_q) + 1'b1 < pend_count_q + 1'b1 && idx_q != PW'(PENDING_DEPTH - 1)) begin
          pend_dest_q[idx_q] <= pend_dest_q[idx_q + 1'b1];
          pend_gate_q[idx_q] <= pend_gate_q[idx_q + 1'b1];
          pend_time_q[idx_q] <= pend_time_q[idx_q + 1'b1];
        end
        idx_q <= idx_q + 1'b1;
      end
      if (ctrl_i.scan) begin
        g_q <= g_q + 1'b1;
        if (g_q != '0 && avail_w[g_idx_w - 1'b1]) begin
          if (!best_set_q || (q_valid_q[dest_q][g_idx_w - 1'b1] ? qrd_q : initial_q_i) < bq_q) begin
            best_set_q <= 1'b1;
            best_q <= g_idx_w - 1'b1;
            bq_q <= q_valid_q[dest_q][g_idx_w - 1'b1] ? qrd_q : initial_q_i;
          end
        end
      end
      if (ctrl_i.finish) begin
        full_q <= 1'b0;
        gate_q <= '0;
        kind_q <= KindNone;
        if ((act_q == ActData || act_q == ActResp) && count_w != '0) begin
          if (first_found_w) begin
            kind_q <= KindExplore;
            gate_q <= first_w;
            explored_q[dest_q][first_w] <= 1'b1;
          end else if (rthr_q < epsilon_i) begin
            kind_q <= KindRandom;
            gate_q <= rand_g_w;
          end else begin
            kind_q <= KindGreedy;
            if (avail_w[MAX_GATES-1] && (!best_set_q ||
                (q_valid_q[dest_q][MAX_GATES-1] ? qrd_q : initial_q_i) < bq_q))
              gate_q <= GW'(MAX_GATES - 1);
            else
              gate_q <= best_q;
          end
          if (act_q == ActData) begin
            if (pend_count_q < PCW'(PENDING_DEPTH)) begin
              pend_dest_q[PW'(pend_count_q)] <= dest_q;
              pend_gate_q[PW'(pend_count_q)] <= first_found_w ? first_w :
                (rthr_q < epsilon_i) ? rand_g_w :
                ((avail_w[MAX_GATES-1] && (!best_set_q ||
                (q_valid_q[dest_q][MAX_GATES-1] ? qrd_q : initial_q_i) < bq_q))
                ? GW'(MAX_GATES - 1) : best_q);
              pend_time_q[PW'(pend_count_q)] <= now_q;
              pend_count_q <= pend_count_q + 1'b1;
            end else begin
              full_q <= 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      ge_q <= rtt_q >= (q_valid_q[src_q][in_gate_q[GW-1:0]] ? qrd_q : initial_q_i);
      diff_q <= (rtt_q >= (q_valid_q[src_q][in_gate_q[GW-1:0]] ? qrd_q : initial_q_i)) ?
                rtt_q - (q_valid_q[src_q][in_gate_q[GW-1:0]] ? qrd_q : initial_q_i) :
                (q_valid_q[src_q][in_gate_q[GW-1:0]] ? qrd_q : initial_q_i) - rtt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      forwarded_o <= (kind_q != KindNone);
      out_gate_o <= 3'(gate_q);
      choice_kind_o <= kind_q;
      learned_o <= learned_q;
      new_q_o <= nq_q;
      pending_full_o <= full_q;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/q_routing_gate_select.sv =====
// Top level of the gate selector: stream ports, registers and output stage.
// A data request runs the gate scan, then the choice and the output load; a response
// first searches its pending list and, on a hit, reads, multiplies and learns, then
// compacts the list, before the same gate scan. One item at a time: the next is
// accepted once the result is loaded. Reset clears the tables' valid and explored bits,
// the pending count and the output valid, and loads the configuration defaults.
`default_nettype none
module q_routing_gate_select #(
  parameter int PENDING_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // dest, src, in_gate, has_in_gate, now, rand_threshold, rand_pick, pad
  input  wire logic [79:0] s_axis_tdata,
  // action
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // forwarded, out_gate, learned, new_q, pending_full, pad
  output logic [47:0]      m_axis_tdata,
  // choice_kind
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [39:0] cfg_wdata_i
);
  import qrg_pkg::*;
  logic [15:0] rate_q, eps_q;
  logic [39:0] initq_q;
  logic [3:0] gates_q;
  logic busy, in_fire, valid_q;
  ctrl_t ctrl;
  stat_t stat;
  logic fwd, lrn, full;
  logic [2:0] og;
  logic [1:0] kind;
  logic [39:0] nq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 16'd6554;
      eps_q <= 16'd6554;
      initq_q <= 40'd256;
      gates_q <= 4'd8;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRate: rate_q <= cfg_wdata_i[15:0];
          RegEps: eps_q <= cfg_wdata_i[15:0];
          RegInitQ: initq_q <= cfg_wdata_i;
          RegGates: gates_q <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (ctrl.out_load) valid_q <= 1'b1;
      else if (m_axis_tready) valid_q <= 1'b0;
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata = {2'd0, full, nq, lrn, og, fwd};
  assign m_axis_tuser = kind;

  qrg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_free_i(!valid_q || m_axis_tready),
    .stat_i(stat), .ctrl_o(ctrl), .busy_o(busy)
  );

  qrg_datapath #(.PENDING_DEPTH(PENDING_DEPTH)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .action_i(s_axis_tuser), .dest_i(s_axis_tdata[3:0]), .src_i(s_axis_tdata[7:4]),
    .in_gate_i(s_axis_tdata[10:8]), .has_in_gate_i(s_axis_tdata[11]),
    .now_i(s_axis_tdata[43:12]), .rand_threshold_i(s_axis_tdata[59:44]),
    .rand_pick_i(s_axis_tdata[75:60]),
    .learning_rate_i(rate_q), .epsilon_i(eps_q), .initial_q_i(initq_q),
    .num_gates_i(gates_q),
    .forwarded_o(fwd), .out_gate_o(og), .choice_kind_o(kind), .learned_o(lrn),
    .new_q_o(nq), .pending_full_o(full)
  );
endmodule
`default_nettype wire

// ===== hdl/qrg_checker.sv =====
// Port checker for the gate selector, bound to the top level.
`default_nettype none
`include "q_routing_gate_select_assert.svh"
module qrg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  `QRG_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `QRG_ASSERT_IMPL(a_drop, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0],
                   m_axis_tdata[3:1] == 3'd0)
  `QRG_ASSERT_NEXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `QRG_ASSERT_IMPL(a_kind, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tuser != 2'd0))
endmodule
bind q_routing_gate_select qrg_checker u_chk (.*);
`default_nettype wire
